/* src/mcmc_pkg.sv */
// Shared types, constants and command struct for the matrix chain cost block.
package mcmc_pkg;

   localparam int MAX_MATRICES_DEF = 16;
   localparam int DIM_BITS_DEF     = 12;
   localparam int DIM_FIELD_W      = 12;
   localparam int COST_W           = 40;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef struct packed {
      logic [DIM_FIELD_W-1:0] dimension;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] min_cost;
      logic              error;
   } rsp_type;

   typedef struct packed {
      logic dim_we;
      logic setup;
      logic step;
      logic write;
      logic respond;
      logic err;
      logic zero;
   } cmd_type;

endpackage

/* src/mcmc_dp.sv */
// Datapath: dimension and cost memories, multiply-add pipeline and result register.
module mcmc_dp #(
   parameter int MAX_MATRICES = mcmc_pkg::MAX_MATRICES_DEF,
   parameter int DIM_BITS     = mcmc_pkg::DIM_BITS_DEF,
   parameter int IDX_W        = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1,
   parameter int DA_W         = $clog2(MAX_MATRICES + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mcmc_pkg::cmd_type                  cmd,
   input  logic [DA_W-1:0]                    dim_waddr,
   input  logic [IDX_W-1:0]                   idx_i,
   input  logic [IDX_W-1:0]                   idx_k,
   input  logic [IDX_W-1:0]                   idx_j,
   input  logic [mcmc_pkg::DIM_FIELD_W-1:0]   req_dimension,
   output logic                               pipe_busy,
   output logic                               rsp_strobe,
   output mcmc_pkg::rsp_type                  rsp_payload
);
   import mcmc_pkg::*;

   localparam int DIMS   = MAX_MATRICES + 1;
   localparam int P1_W   = 2 * DIM_BITS;
   localparam int P2_W   = 3 * DIM_BITS;
   localparam int EXT_W  = P2_W + COST_W;
   localparam int CA_W   = 2 * IDX_W;
   localparam int CDEPTH = 1 << CA_W;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? COST_MAX : s[COST_W-1:0];
   endfunction

   logic [DIM_BITS-1:0] dim_mem [DIMS];
   logic [COST_W-1:0]   cost_mem [CDEPTH];

   logic [DIM_BITS-1:0] dim_in;
   logic [DA_W-1:0]     addr_a;
   logic [DA_W-1:0]     addr_b;
   logic [IDX_W-1:0]    k1_idx;

   logic [DIM_BITS-1:0] di_ff, dj_ff, dk_ff;
   logic [COST_W-1:0]   cl_ff, cr_ff;
   logic                lz_ff, rz_ff;
   logic [P1_W-1:0]     p1_ff;
   logic [P2_W-1:0]     p2_ff;
   logic [COST_W-1:0]   sum_ff, sum2_ff;
   logic [COST_W-1:0]   best_ff;
   logic                v1_ff, v2_ff, v3_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;

   logic [COST_W-1:0]   term;
   logic [COST_W-1:0]   cand;

   assign dim_in = DIM_BITS'(req_dimension);
   assign k1_idx = idx_k + IDX_W'(1);
   assign addr_a = cmd.setup ? DA_W'(idx_i) : DA_W'(idx_k) + DA_W'(1);
   assign addr_b = DA_W'(idx_j) + DA_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.dim_we) begin
         dim_mem[dim_waddr] <= dim_in;
      end
      dk_ff <= dim_mem[addr_a];
      if (cmd.setup) begin
         di_ff <= dim_mem[addr_a];
         dj_ff <= dim_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         cost_mem[{idx_i, idx_j}] <= best_ff;
      end
      cl_ff <= cost_mem[{idx_i, idx_k}];
      cr_ff <= cost_mem[{k1_idx, idx_j}];
   end

   always_comb begin
      term = (EXT_W'(p2_ff) > EXT_W'(COST_MAX)) ? COST_MAX : COST_W'(p2_ff);
      cand = sat_add(sum2_ff, term);
   end

   always_ff @(posedge clock) begin
      lz_ff   <= (idx_k == idx_i);
      rz_ff   <= (k1_idx == idx_j);
      p1_ff   <= P1_W'(di_ff) * P1_W'(dk_ff);
      sum_ff  <= sat_add(lz_ff ? '0 : cl_ff, rz_ff ? '0 : cr_ff);
      p2_ff   <= P2_W'(p1_ff) * P2_W'(dj_ff);
      sum2_ff <= sum_ff;
      if (cmd.setup) begin
         best_ff <= COST_MAX;
      end else if (v3_ff && (cand < best_ff)) begin
         best_ff <= cand;
      end
      if (cmd.respond) begin
         rsp_ff.error    <= cmd.err;
         rsp_ff.min_cost <= (cmd.err || cmd.zero) ? '0 : best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= cmd.step;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign pipe_busy   = v1_ff || v2_ff || v3_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/mcmc_ctrl.sv */
// Controller: dimension loading, interval sequencing and result commands.
module mcmc_ctrl #(
   parameter int MAX_MATRICES = mcmc_pkg::MAX_MATRICES_DEF,
   parameter int IDX_W        = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1,
   parameter int DA_W         = $clog2(MAX_MATRICES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_last,
   input  logic              pipe_busy,
   output logic              busy,
   output mcmc_pkg::cmd_type cmd,
   output logic [DA_W-1:0]   dim_waddr,
   output logic [IDX_W-1:0]  idx_i,
   output logic [IDX_W-1:0]  idx_k,
   output logic [IDX_W-1:0]  idx_j
);
   import mcmc_pkg::*;

   localparam int DIMS  = MAX_MATRICES + 1;
   localparam int CNT_W = $clog2(MAX_MATRICES + 2);
   localparam int SW    = DA_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_STEP  = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, cnt_next;
   logic             ovf_ff, ovf_in, ovf_next;
   logic [DA_W-1:0]  mats_ff, mats_in;
   logic [DA_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [SW-1:0]    j_w;

   assign j_w = SW'(i_ff) + SW'(len_ff) - SW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      mats_in   = mats_ff;
      len_in    = len_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      cnt_next  = count_ff;
      ovf_next  = ovf_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(DIMS)) begin
                  cmd.dim_we = 1'b1;
                  cnt_next   = count_ff + CNT_W'(1);
               end else begin
                  ovf_next = 1'b1;
               end
               count_in = cnt_next;
               ovf_in   = ovf_next;
               if (req_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (ovf_next || (cnt_next < CNT_W'(2))) begin
                     cmd.respond = 1'b1;
                     cmd.err     = 1'b1;
                  end else if (cnt_next == CNT_W'(2)) begin
                     cmd.respond = 1'b1;
                     cmd.zero    = 1'b1;
                  end else begin
                     mats_in  = DA_W'(cnt_next - CNT_W'(1));
                     len_in   = DA_W'(2);
                     i_in     = '0;
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            k_in      = i_ff;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if ((SW'(k_ff) + SW'(1)) == j_w) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               cmd.write = 1'b1;
               if ((SW'(i_ff) + SW'(len_ff)) == SW'(mats_ff)) begin
                  if (len_ff == mats_ff) begin
                     cmd.respond = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     len_in   = len_ff + DA_W'(1);
                     i_in     = '0;
                     state_in = ST_SETUP;
                  end
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      mats_ff <= mats_in;
      len_ff  <= len_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign dim_waddr = count_ff[DA_W-1:0];
   assign idx_i     = i_ff;
   assign idx_k     = k_ff;
   assign idx_j     = j_w[IDX_W-1:0];

endmodule

/* src/matrix_chain_min_cost.sv */
// Top level of the matrix chain minimum multiplication cost block.
//
//   Channel  Ports                        Handshake
//   request  start, busy, req_payload     beat taken when start is high and busy is low
//   response rsp_strobe, rsp_payload      beat valid for the one cycle rsp_strobe is high
//
// Dimensions load at one beat per cycle while busy is low. After the closing beat
// of a chain of m matrices the block stays busy while it runs every interval of
// the chain through the single multiply-add pipeline and the two read ports of
// the cost memory. The registered response appears in the cycle after the
// last cost write, or the cycle after the closing beat for an error or one matrix.
// Reset returns the block to idle with an empty chain; the receiver cannot stall.
module matrix_chain_min_cost #(
   parameter int MAX_MATRICES = mcmc_pkg::MAX_MATRICES_DEF,
   parameter int DIM_BITS     = mcmc_pkg::DIM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mcmc_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output mcmc_pkg::rsp_type rsp_payload
);
   import mcmc_pkg::*;

   localparam int IDX_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
   localparam int DA_W  = $clog2(MAX_MATRICES + 1);

   cmd_type          cmd;
   logic             pipe_busy;
   logic [DA_W-1:0]  dim_waddr;
   logic [IDX_W-1:0] idx_i, idx_k, idx_j;

   mcmc_ctrl #(
      .MAX_MATRICES (MAX_MATRICES),
      .IDX_W        (IDX_W),
      .DA_W         (DA_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_payload.last),
      .pipe_busy (pipe_busy),
      .busy      (busy),
      .cmd       (cmd),
      .dim_waddr (dim_waddr),
      .idx_i     (idx_i),
      .idx_k     (idx_k),
      .idx_j     (idx_j)
   );

   mcmc_dp #(
      .MAX_MATRICES (MAX_MATRICES),
      .DIM_BITS     (DIM_BITS),
      .IDX_W        (IDX_W),
      .DA_W         (DA_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dim_waddr     (dim_waddr),
      .idx_i         (idx_i),
      .idx_k         (idx_k),
      .idx_j         (idx_j),
      .req_dimension (req_payload.dimension),
      .pipe_busy     (pipe_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload)
   );

endmodule

/* src/mcmc_checker.sv */
// Port-level checker for the matrix chain cost block, bound to the top level.
module mcmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mcmc_pkg::req_type req_payload,
   input logic              rsp_strobe,
   input mcmc_pkg::rsp_type rsp_payload
);
   import mcmc_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.error) |-> (rsp_payload.min_cost == '0))
      else $error("error response carries a nonzero cost");

   a_open_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_payload.last) |=> !rsp_strobe)
      else $error("response after a beat that does not close the chain");

   a_close_acts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.last) |=> (rsp_strobe || busy))
      else $error("closing beat neither answered nor started work");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("work ended without a response");

endmodule

bind matrix_chain_min_cost mcmc_checker u_mcmc_checker (.*);
